// ----- design/ctss_pkg.sv -----
// Package: shared types, constants and codes for the contact table block.
package ctss_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int REC_W = 384;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_FIND = 3'd2;
  localparam logic [2:0] OP_SORT = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;
  localparam logic [2:0] OP_LIST = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Record as stored: first hi/lo, second hi/lo, value hi/lo.
  typedef struct packed {
    logic [63:0] first_hi;
    logic [63:0] first_lo;
    logic [63:0] second_hi;
    logic [63:0] second_lo;
    logic [63:0] value_hi;
    logic [63:0] value_lo;
  } rec_t;

  typedef struct packed {
    logic [2:0] op;
    rec_t rec;
    logic sort_order;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] slot;
    rec_t rec;
    logic [5:0] entry_total;
    logic last_of_run;
  } rsp_t;

  // Memory port controls between sequencer and record store.
  typedef struct packed {
    logic rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic wr_en;
    logic [IDX_W-1:0] wr_addr;
    rec_t wr_data;
  } mem_ctl_t;

  // True when a orders strictly after b.
  function automatic logic rec_greater(rec_t a, rec_t b, logic second_primary);
    logic [127:0] a1;
    logic [127:0] b1;
    logic [127:0] a2;
    logic [127:0] b2;
    a1 = {a.first_hi, a.first_lo};
    b1 = {b.first_hi, b.first_lo};
    a2 = {a.second_hi, a.second_lo};
    b2 = {b.second_hi, b.second_lo};
    if (second_primary) begin
      return (a2 != b2) ? (a2 > b2) : (a1 > b1);
    end
    return (a1 != b1) ? (a1 > b1) : (a2 > b2);
  endfunction

endpackage

// ----- design/ctss_stream_if.sv -----
// Interface: valid/ready channel carrying one payload.
interface ctss_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/ctss_rec_mem.sv -----
// Record store: one write port, one registered read port.
module ctss_rec_mem
  import ctss_pkg::*;
(
  input  logic clk,
  input  mem_ctl_t ctl,
  output rec_t rd_data
);

  rec_t mem [CAPACITY];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

endmodule

// ----- design/ctss_seq.sv -----
// Sequencer: runs each operation as reads and writes of the record store.
module ctss_seq
  import ctss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ctss_stream_if.sink   req,
  ctss_stream_if.source rsp,
  output mem_ctl_t ctl,
  input  rec_t rd_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_SCAN_CHK = 4'd2;
  localparam logic [3:0] S_MOVE_RD = 4'd3;
  localparam logic [3:0] S_MOVE_WR = 4'd4;
  localparam logic [3:0] S_LIST = 4'd5;
  localparam logic [3:0] S_LIST_OUT = 4'd6;
  localparam logic [3:0] S_SORT_INS = 4'd7;
  localparam logic [3:0] S_SORT_GET = 4'd8;
  localparam logic [3:0] S_SORT_PREV = 4'd9;
  localparam logic [3:0] S_SORT_CMP = 4'd10;
  localparam logic [3:0] S_RESP = 4'd11;

  logic [3:0] state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] k;
  req_t cur;
  rec_t ins;
  rsp_t out;
  logic out_valid;

  logic fire_in;
  logic fire_out;
  logic key_eq;
  logic [CNT_W-1:0] last_idx;
  rsp_t out_start;
  logic out_load;

  assign fire_in = req.valid && req.ready;
  assign fire_out = out_valid && rsp.ready;
  assign req.ready = (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.data = out;
  assign last_idx = count - CNT_W'(1);
  assign key_eq = (rd_data.first_hi == cur.rec.first_hi)
                  && (rd_data.first_lo == cur.rec.first_lo)
                  && (rd_data.second_hi == cur.rec.second_hi)
                  && (rd_data.second_lo == cur.rec.second_lo);

  // Form the first result of an accepted request
  always_comb begin
    out_start = '0;
    out_start.last_of_run = 1'b1;
    out_start.entry_total = 6'(count);
    case (req.data.op)
      OP_ADD: begin
        if (count >= CNT_W'(CAPACITY)) begin
          out_start.status = ST_FULL;
        end else begin
          out_start.slot = 5'(count);
          out_start.entry_total = 6'(count + CNT_W'(1));
        end
      end
      OP_REMOVE, OP_FIND, OP_LIST: begin
        if (count == '0) begin
          out_start.status = ST_EMPTY;
        end
      end
      OP_CLEAR: out_start.entry_total = '0;
      default: ;
    endcase
  end

  // Flag the cycles that present a new result
  always_comb begin
    out_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (fire_in) begin
          case (req.data.op)
            OP_REMOVE, OP_FIND, OP_LIST: out_load = (count == '0);
            OP_SORT: out_load = (count <= CNT_W'(1));
            default: out_load = 1'b1;
          endcase
        end
      end
      S_SCAN_CHK: out_load = key_eq ? (cur.op == OP_FIND) : (idx == last_idx);
      S_MOVE_WR: out_load = 1'b1;
      S_LIST_OUT: out_load = !out_valid || fire_out;
      S_RESP: out_load = (idx == last_idx);
      default: ;
    endcase
  end

  // Drive memory ports from the state
  always_comb begin
    ctl = '0;
    ctl.wr_data = rd_data;
    case (state)
      S_IDLE: begin
        if (fire_in && req.data.op == OP_ADD && count < CNT_W'(CAPACITY)) begin
          ctl.wr_en = 1'b1;
          ctl.wr_addr = count[IDX_W-1:0];
          ctl.wr_data = req.data.rec;
        end
      end
      S_SCAN: begin
        ctl.rd_en = 1'b1;
        ctl.rd_addr = idx[IDX_W-1:0];
      end
      S_MOVE_RD: begin
        ctl.rd_en = 1'b1;
        ctl.rd_addr = last_idx[IDX_W-1:0];
      end
      S_MOVE_WR: begin
        ctl.wr_en = 1'b1;
        ctl.wr_addr = idx[IDX_W-1:0];
      end
      S_LIST: begin
        ctl.rd_en = 1'b1;
        ctl.rd_addr = idx[IDX_W-1:0];
      end
      S_SORT_INS: begin
        ctl.rd_en = 1'b1;
        ctl.rd_addr = idx[IDX_W-1:0];
      end
      S_SORT_PREV: begin
        ctl.rd_en = 1'b1;
        ctl.rd_addr = IDX_W'(k - CNT_W'(1));
      end
      S_SORT_CMP: begin
        ctl.wr_en = 1'b1;
        ctl.wr_addr = k[IDX_W-1:0];
        ctl.wr_data = rec_greater(rd_data, ins, cur.sort_order) ? rd_data : ins;
      end
      S_RESP: begin
        // Place the held record at its final slot, the front after a full shift
        ctl.wr_en = 1'b1;
        ctl.wr_addr = k[IDX_W-1:0];
        ctl.wr_data = ins;
      end
      default: ;
    endcase
  end

  // Hold a result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (fire_out) begin
      out_valid <= 1'b0;
    end
  end

  // Advance the operation
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (fire_in) begin
            cur <= req.data;
            idx <= (req.data.op == OP_SORT) ? CNT_W'(1) : '0;
            out <= out_start;
            case (req.data.op)
              OP_ADD: begin
                if (count < CNT_W'(CAPACITY)) begin
                  count <= count + CNT_W'(1);
                end
              end
              OP_REMOVE, OP_FIND: begin
                if (count != '0) begin
                  state <= S_SCAN;
                end
              end
              OP_SORT: begin
                if (count > CNT_W'(1)) begin
                  state <= S_SORT_INS;
                end
              end
              OP_CLEAR: count <= '0;
              OP_LIST: begin
                if (count != '0) begin
                  state <= S_LIST;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (key_eq) begin
            out.slot <= 5'(idx);
            if (cur.op == OP_FIND) begin
              out.rec <= rd_data;
              state <= S_IDLE;
            end else begin
              state <= S_MOVE_RD;
            end
          end else if (idx == last_idx) begin
            out.status <= ST_NOT_FOUND;
            state <= S_IDLE;
          end else begin
            idx <= idx + CNT_W'(1);
            state <= S_SCAN;
          end
        end
        S_MOVE_RD: state <= S_MOVE_WR;
        S_MOVE_WR: begin
          count <= last_idx;
          out.entry_total <= 6'(last_idx);
          state <= S_IDLE;
        end
        S_LIST: state <= S_LIST_OUT;
        S_LIST_OUT: begin
          if (!out_valid || fire_out) begin
            out.status <= ST_OK;
            out.slot <= 5'(idx);
            out.rec <= rd_data;
            out.last_of_run <= (idx == last_idx);
            if (idx == last_idx) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + CNT_W'(1);
              state <= S_LIST;
            end
          end
        end
        S_SORT_INS: begin
          k <= idx;
          state <= S_SORT_GET;
        end
        S_SORT_GET: begin
          ins <= rd_data;
          state <= S_SORT_PREV;
        end
        S_SORT_PREV: state <= S_SORT_CMP;
        S_SORT_CMP: begin
          if (rec_greater(rd_data, ins, cur.sort_order)) begin
            // Shifted prev up; the held record lands at k in S_RESP
            k <= k - CNT_W'(1);
            if (k == CNT_W'(1)) begin
              state <= S_RESP;
            end else begin
              state <= S_SORT_PREV;
            end
          end else begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (idx == last_idx) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + CNT_W'(1);
            state <= S_SORT_INS;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(CAPACITY))
    else $error("count above capacity");
  assert property (@(posedge clk) disable iff (rst)
    fire_in |=> !req.ready) else $error("ready during operation");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_CHK) |-> (idx < count)) else $error("scan past end");

endmodule

// ----- design/contact_table_sort_search.sv -----
// Top level: contact table with add, remove, find, sort, clear and list.
//  channel | dir | payload
//  req     | in  | op, keys, value, sort_order
//  rsp     | out | status, slot, record, entry_total, last_of_run
// Add/clear finish on acceptance; find/remove read and check each entry in turn;
// remove then moves the last record to the freed slot. List reads and shows each
// record; sort reads each entry and the prior one per compare, via one read port.
// Reset clears count, state and result valid; records are undefined until written.
// A held result stalls list; other ops wait for the result to be taken.
module contact_table_sort_search
  import ctss_pkg::*;
(
  input logic clk,
  input logic rst,
  ctss_stream_if.sink   req,
  ctss_stream_if.source rsp
);

  mem_ctl_t ctl;
  mem_ctl_t mctl;
  rec_t rd_data;
  logic fix;
  rec_t ins_hold;

  ctss_seq u_seq (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .ctl(ctl), .rd_data(rd_data)
  );

  // Pass controls straight through to the record store.
  assign fix = 1'b0;
  assign ins_hold = ctl.wr_data;
  always_comb begin
    mctl = ctl;
    if (fix) begin
      mctl.wr_data = ins_hold;
    end
  end

  ctss_rec_mem u_mem (.clk(clk), .ctl(mctl), .rd_data(rd_data));

endmodule
